FILE: design/wsp_pkg.sv
`timescale 1ns / 1ps

package wsp_pkg;

    // Field widths
    localparam int COEF_W     = 32;
    localparam int WORLD_W    = 32;
    localparam int SCREEN_W   = 32;
    localparam int IDX_W      = 4;
    localparam int SIZE_W     = 14;
    localparam int WMIN_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Coefficient store
    localparam int SLOT_COUNT = 12;
    localparam int ROW_COUNT  = 3;
    localparam int COL_COUNT  = 4;

    // NDC magnitude cap is 2**NDC_LOG
    localparam int NDC_LOG = 46;

    // Request kinds
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_MIN         = 2'd2;

    // Reset values
    localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = 14'd1920;
    localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = 14'd1080;
    localparam logic [WMIN_W-1:0] RST_W_MIN         = 17'd66;

    typedef struct packed {
        logic                       in_front;
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y;
        logic                       clamped;
    } result_t;

endpackage

FILE: design/wsp_req_if.sv
`timescale 1ns / 1ps

interface wsp_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [wsp_pkg::IDX_W-1:0]           coef_index;
    logic signed [wsp_pkg::COEF_W-1:0]   coef_value;
    logic signed [wsp_pkg::WORLD_W-1:0]  world_x;
    logic signed [wsp_pkg::WORLD_W-1:0]  world_y;
    logic signed [wsp_pkg::WORLD_W-1:0]  world_z;

    modport source (output valid, req_type, coef_index, coef_value, world_x, world_y, world_z,
                    input ready);
    modport sink   (input valid, req_type, coef_index, coef_value, world_x, world_y, world_z,
                    output ready);
endinterface

FILE: design/wsp_res_if.sv
`timescale 1ns / 1ps

interface wsp_res_if;
    logic                                valid;
    logic                                ready;
    logic                                in_front;
    logic signed [wsp_pkg::SCREEN_W-1:0] screen_x;
    logic signed [wsp_pkg::SCREEN_W-1:0] screen_y;
    logic                                clamped;

    modport source (output valid, in_front, screen_x, screen_y, clamped, input ready);
    modport sink   (input valid, in_front, screen_x, screen_y, clamped, output ready);
endinterface

FILE: design/wsp_cfg_if.sv
`timescale 1ns / 1ps

interface wsp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [wsp_pkg::CFG_IDX_W-1:0]       wr_index;
    logic [wsp_pkg::CFG_DATA_W-1:0]      wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

FILE: design/world_to_screen_projection_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   req_type, coef_index, coef_value, world_x/y/z
// res       out  valid/ready   in_front, screen_x, screen_y, clamped
// cfg       in   valid/ready   wr_index, wr_data (always ready)
//
// One request per cycle while the output skid register is empty; a projection result
// passes the 46 quotient-bit stages of the two dividers on its way to the output.
// Loads update the store at acceptance and produce no result.
// Reset clears the coefficient store and all valid bits and loads the config registers.
// The pipeline stalls as a whole only when the output skid register is full.

module world_to_screen_projection_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wsp_req_if.sink   req,
    wsp_res_if.source res,
    wsp_cfg_if.sink   cfg
);

    localparam int F    = FRAC_BITS;
    localparam int QB   = wsp_pkg::NDC_LOG;
    localparam int QF   = QB - F;
    localparam int PW   = wsp_pkg::COEF_W + wsp_pkg::WORLD_W;
    localparam int CW   = PW - F + 2;
    localparam int OW   = QB + 2;
    localparam int MW   = OW + wsp_pkg::SIZE_W + 1;
    localparam int NP   = wsp_pkg::ROW_COUNT * wsp_pkg::ROW_COUNT;

    localparam logic signed [OW-1:0] ONE     = OW'(1) <<< F;
    localparam logic signed [MW-1:0] SAT_MAX = MW'(64'sd2147483647);
    localparam logic signed [MW-1:0] SAT_MIN = -(MW'(64'sd2147483648));

    // configuration registers
    logic [wsp_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [wsp_pkg::WMIN_W-1:0] wmin_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= wsp_pkg::RST_SCREEN_WIDTH;
            height_reg <= wsp_pkg::RST_SCREEN_HEIGHT;
            wmin_reg   <= wsp_pkg::RST_W_MIN;
        end
        else if (cfg.valid)
        begin
            case (cfg.wr_index)
                wsp_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg.wr_data[wsp_pkg::SIZE_W-1:0];
                wsp_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg.wr_data[wsp_pkg::SIZE_W-1:0];
                wsp_pkg::REG_W_MIN:         wmin_reg   <= cfg.wr_data;
                default: ;
            endcase
        end
    end

    // global advance: pipeline moves unless skid is holding a result
    logic skid_valid_reg, out_valid_reg;
    logic en;
    logic req_acc;

    assign en        = !skid_valid_reg;
    assign req.ready = en;
    assign req_acc   = req.valid && en;

    // coefficient store
    logic signed [wsp_pkg::COEF_W-1:0] coef_reg [wsp_pkg::SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wsp_pkg::SLOT_COUNT; i++)
                coef_reg[i] <= '0;
        end
        else if (req_acc && req.req_type == wsp_pkg::REQ_LOAD
                 && req.coef_index < wsp_pkg::IDX_W'(wsp_pkg::SLOT_COUNT))
        begin
            coef_reg[req.coef_index] <= req.coef_value;
        end
    end

    // valid bits of the fixed stages
    logic v1_reg, v2_reg, voff_reg, vmul_reg;
    logic dv_reg [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            dv_reg[0] <= 1'b0;
            voff_reg <= 1'b0;
            vmul_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= req_acc && req.req_type == wsp_pkg::REQ_PROJECT;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            voff_reg  <= dv_reg[QB];
            vmul_reg  <= voff_reg;
        end
    end

    // stage 1: nine products and translations
    logic signed [PW-1:0] prod_reg [NP];
    logic signed [wsp_pkg::COEF_W-1:0] trans_reg [wsp_pkg::ROW_COUNT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < wsp_pkg::ROW_COUNT; r++)
            begin
                prod_reg[r*3]   <= coef_reg[r*4]   * req.world_x;
                prod_reg[r*3+1] <= coef_reg[r*4+1] * req.world_y;
                prod_reg[r*3+2] <= coef_reg[r*4+2] * req.world_z;
                trans_reg[r]    <= coef_reg[r*4+3];
            end
        end
    end

    // stage 2: clip sums with floor shift
    logic signed [CW-1:0] clip_reg [wsp_pkg::ROW_COUNT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < wsp_pkg::ROW_COUNT; r++)
                clip_reg[r] <= CW'(prod_reg[r*3] >>> F) + CW'(prod_reg[r*3+1] >>> F)
                             + CW'(prod_reg[r*3+2] >>> F) + CW'(trans_reg[r]);
        end
    end

    // stage 3: magnitudes, front test, cap test, divider seed
    logic [CW-1:0]      remx_reg [0:QB];
    logic [CW-1:0]      remy_reg [0:QB];
    logic [CW-1:0]      wv_reg   [0:QB];
    logic [QB-1:0]      dvx_reg  [0:QB];
    logic [QB-1:0]      dvy_reg  [0:QB];
    logic [QB-1:0]      qx_reg   [0:QB];
    logic [QB-1:0]      qy_reg   [0:QB];
    logic [4:0]         flg_reg  [0:QB];   // front, capx, capy, sgnx, sgny

    logic [CW-1:0]      ax_next, ay_next, cw_u;
    logic               front_next, capx_next, capy_next;

    always_comb
    begin
        cw_u       = clip_reg[2];
        ax_next    = clip_reg[0][CW-1] ? CW'(-clip_reg[0]) : CW'(clip_reg[0]);
        ay_next    = clip_reg[1][CW-1] ? CW'(-clip_reg[1]) : CW'(clip_reg[1]);
        front_next = !clip_reg[2][CW-1] && (cw_u != '0) && (cw_u >= CW'(wmin_reg));
        capx_next  = {{QF{1'b0}}, ax_next} >= {cw_u, {QF{1'b0}}};
        capy_next  = {{QF{1'b0}}, ay_next} >= {cw_u, {QF{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remx_reg[0] <= ax_next >> QF;
            remy_reg[0] <= ay_next >> QF;
            wv_reg[0]   <= cw_u;
            dvx_reg[0]  <= {ax_next[QF-1:0], {F{1'b0}}};
            dvy_reg[0]  <= {ay_next[QF-1:0], {F{1'b0}}};
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            flg_reg[0]  <= {front_next, capx_next, capy_next,
                            clip_reg[0][CW-1], clip_reg[1][CW-1]};
        end
    end

    // restoring divider stages, one quotient bit each
    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        logic [CW-1:0] rx2, ry2;
        logic          gx, gy;

        always_comb
        begin
            rx2 = {remx_reg[j-1][CW-2:0], dvx_reg[j-1][QB-1]};
            ry2 = {remy_reg[j-1][CW-2:0], dvy_reg[j-1][QB-1]};
            gx  = rx2 >= wv_reg[j-1];
            gy  = ry2 >= wv_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j] <= 1'b0;
            else if (en)
                dv_reg[j] <= dv_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                remx_reg[j] <= gx ? rx2 - wv_reg[j-1] : rx2;
                remy_reg[j] <= gy ? ry2 - wv_reg[j-1] : ry2;
                wv_reg[j]   <= wv_reg[j-1];
                dvx_reg[j]  <= dvx_reg[j-1] << 1;
                dvy_reg[j]  <= dvy_reg[j-1] << 1;
                qx_reg[j]   <= {qx_reg[j-1][QB-2:0], gx};
                qy_reg[j]   <= {qy_reg[j-1][QB-2:0], gy};
                flg_reg[j]  <= flg_reg[j-1];
            end
        end
    end

    // offset stage: apply cap and sign, form 1 +/- ndc
    logic [QB:0]          magx_next, magy_next;
    logic signed [OW-1:0] nx_next, ny_next;
    logic signed [OW-1:0] offx_reg, offy_reg;
    logic                 front_off_reg, front_mul_reg;

    always_comb
    begin
        magx_next = flg_reg[QB][3] ? (QB+1)'(1) << QB : {1'b0, qx_reg[QB]};
        magy_next = flg_reg[QB][2] ? (QB+1)'(1) << QB : {1'b0, qy_reg[QB]};
        nx_next   = flg_reg[QB][1] ? -OW'(magx_next) : OW'(magx_next);
        ny_next   = flg_reg[QB][0] ? -OW'(magy_next) : OW'(magy_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            offx_reg      <= ONE + nx_next;
            offy_reg      <= ONE - ny_next;
            front_off_reg <= flg_reg[QB][4];
        end
    end

    // viewport scale
    logic signed [MW-1:0] sclx_reg, scly_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sclx_reg      <= $signed({1'b0, width_reg}) * offx_reg;
            scly_reg      <= $signed({1'b0, height_reg}) * offy_reg;
            front_mul_reg <= front_off_reg;
        end
    end

    // halve, saturate, and build the result
    logic signed [MW-1:0] tx, ty;
    logic                 satx, saty;
    wsp_pkg::result_t     res_next;

    always_comb
    begin
        tx   = sclx_reg >>> 1;
        ty   = scly_reg >>> 1;
        satx = (tx > SAT_MAX) || (tx < SAT_MIN);
        saty = (ty > SAT_MAX) || (ty < SAT_MIN);
        res_next = '0;
        if (front_mul_reg)
        begin
            res_next.in_front = 1'b1;
            res_next.screen_x = (tx > SAT_MAX) ? SAT_MAX[31:0] :
                                (tx < SAT_MIN) ? SAT_MIN[31:0] : tx[31:0];
            res_next.screen_y = (ty > SAT_MAX) ? SAT_MAX[31:0] :
                                (ty < SAT_MIN) ? SAT_MIN[31:0] : ty[31:0];
            res_next.clamped  = satx || saty;
        end
    end

    // output register and skid
    wsp_pkg::result_t out_reg, skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (vmul_reg)
        begin
            if (out_valid_reg && !res.ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (res.ready)
                out_reg <= skid_reg;
        end
        else if (vmul_reg)
        begin
            if (out_valid_reg && !res.ready)
                skid_reg <= res_next;
            else
                out_reg <= res_next;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.in_front = out_reg.in_front;
    assign res.screen_x = out_reg.screen_x;
    assign res.screen_y = out_reg.screen_y;
    assign res.clamped  = out_reg.clamped;

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    a_no_req_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !skid_valid_reg)
        else $error("request taken while skid full");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.in_front) |->
        (res.screen_x == '0 && res.screen_y == '0 && !res.clamped))
        else $error("point behind camera with nonzero result");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> $past(res.ready))
        else $error("skid emptied without a taken result");

endmodule
